/* rtl/text_console_cell_writer_macros.svh */
// assertion macros for the console cell writer
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

`ifndef SYNTHESIS

`define TCW_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tcw assertion failed");

`define TCW_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("tcw assertion failed");

`else

`define TCW_ASSERT(label, prop)

`define TCW_ASSERT_NEVER(label, expr)

`endif

`endif

/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 25;

	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [ATTR_W-1:0] FILL_RESET   = 8'h07;

	localparam logic MODE_PUT  = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clear_en;
		logic put_en;
		logic read_en;
		logic fill_en;
		logic res_load;
		logic res_direct;
	} ctl_t;

	typedef struct packed {
		logic scroll_req;
		logic out_free;
		logic clear_last;
		logic fill_last;
	} sts_t;

endpackage

/* rtl/tcw_ctrl.sv */
`timescale 1ns / 1ps

module tcw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          mode,
	input  tcw_pkg::sts_t sts,
	output logic          in_ready,
	output tcw_pkg::ctl_t ctl
);
	import tcw_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_READ) begin
						state_d = ST_FINISH;
					end else if (sts.scroll_req) begin
						state_d = ST_FILL;
					end else if (!sts.out_free) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FILL: begin
				if (sts.fill_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_CLEAR: begin
				ctl.clear_en = 1'b1;
			end
			ST_IDLE: begin
				ctl.put_en  = accept && (mode == MODE_PUT);
				ctl.read_en = accept && (mode == MODE_READ);
				if (accept && (mode == MODE_PUT) && !sts.scroll_req && sts.out_free) begin
					ctl.res_load   = 1'b1;
					ctl.res_direct = 1'b1;
				end
			end
			ST_FILL: begin
				ctl.fill_en = 1'b1;
			end
			ST_FINISH: begin
				ctl.res_load = sts.out_free;
			end
			default: ctl = '0;
		endcase
	end

endmodule

/* rtl/tcw_datapath.sv */
`timescale 1ns / 1ps

module tcw_datapath #(
	parameter int COLS = tcw_pkg::COLS_DEF,
	parameter int ROWS = tcw_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::ATTR_W-1:0]  attribute,
	input  logic [tcw_pkg::ROW_W-1:0]   read_row,
	input  logic [tcw_pkg::COL_W-1:0]   read_col,
	input  tcw_pkg::ctl_t               ctl,
	output tcw_pkg::sts_t               sts,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [tcw_pkg::CELL_W-1:0]  cell_word,
	output logic [tcw_pkg::ROW_W-1:0]   cursor_row_now,
	output logic [tcw_pkg::COL_W-1:0]   cursor_col_now,
	output logic                        did_scroll
);
	import tcw_pkg::*;

	localparam int NCELLS = ROWS * COLS;
	localparam int AW     = $clog2(NCELLS);
	localparam int RW     = $clog2(ROWS);
	localparam int CW     = $clog2(COLS);

	logic [CELL_W-1:0] mem [NCELLS];

	logic [RW-1:0]     cur_row_q;
	logic [CW-1:0]     cur_col_q;
	logic [RW-1:0]     cur_prow_q;
	logic [RW-1:0]     base_q;
	logic [RW-1:0]     fill_row_q;
	logic [CW-1:0]     fill_col_q;
	logic [AW-1:0]     clr_q;
	logic [ATTR_W-1:0] fill_attr_q;
	logic [CELL_W-1:0] rdata_q;
	logic              rd_ok_q;
	logic              res_read_q;
	logic              res_scroll_q;

	logic              newline;
	logic [CW:0]       col_inc;
	logic              wrap;
	logic              adv_row;
	logic              scroll;
	logic [RW-1:0]     next_row;
	logic [CW-1:0]     next_col;
	logic [RW-1:0]     prow_inc;
	logic [RW-1:0]     base_inc;

	logic              rd_ok;
	logic [RW:0]       rd_sum;
	logic [RW-1:0]     rd_prow;
	logic [AW-1:0]     raddr;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;

	// cursor step
	assign newline  = (char_code == NEWLINE_CODE);
	assign col_inc  = {1'b0, cur_col_q} + (CW+1)'(1);
	assign wrap     = !newline && (col_inc == (CW+1)'(COLS));
	assign adv_row  = newline || wrap;
	assign scroll   = adv_row && (cur_row_q == RW'(ROWS - 1));
	assign next_col = adv_row ? '0 : col_inc[CW-1:0];
	assign next_row = (adv_row && !scroll) ? cur_row_q + RW'(1) : cur_row_q;
	assign prow_inc = (cur_prow_q == RW'(ROWS - 1)) ? '0 : cur_prow_q + RW'(1);
	assign base_inc = (base_q == RW'(ROWS - 1)) ? '0 : base_q + RW'(1);

	// read address, rows rotate through base_q
	assign rd_ok   = (32'(read_row) < ROWS) && (32'(read_col) < COLS);
	assign rd_sum  = {1'b0, RW'(32'(read_row))} + {1'b0, base_q};
	assign rd_prow = (rd_sum >= (RW+1)'(ROWS)) ? RW'(rd_sum - (RW+1)'(ROWS)) : rd_sum[RW-1:0];
	assign raddr   = AW'(32'(rd_prow) * COLS + 32'(read_col));

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '0;
		if (ctl.clear_en) begin
			we = 1'b1;
		end else if (ctl.fill_en) begin
			we    = 1'b1;
			waddr = AW'(32'(fill_row_q) * COLS + 32'(fill_col_q));
			wdata = {fill_attr_q, SPACE_CODE};
		end else if (ctl.put_en && !newline) begin
			we    = 1'b1;
			waddr = AW'(32'(cur_prow_q) * COLS + 32'(cur_col_q));
			wdata = {attribute, char_code};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.read_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign sts.scroll_req = scroll;
	assign sts.out_free   = !out_valid || out_ready;
	assign sts.clear_last = (clr_q == AW'(NCELLS - 1));
	assign sts.fill_last  = (fill_col_q == CW'(COLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			cur_prow_q   <= '0;
			base_q       <= '0;
			fill_row_q   <= '0;
			fill_col_q   <= '0;
			clr_q        <= '0;
			fill_attr_q  <= FILL_RESET;
			rd_ok_q      <= 1'b0;
			res_read_q   <= 1'b0;
			res_scroll_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				fill_attr_q <= cfg_data;
			end
			if (ctl.clear_en) begin
				clr_q <= clr_q + AW'(1);
			end
			if (ctl.fill_en) begin
				fill_col_q <= fill_col_q + CW'(1);
			end
			if (ctl.read_en) begin
				rd_ok_q      <= rd_ok;
				res_read_q   <= 1'b1;
				res_scroll_q <= 1'b0;
			end
			if (ctl.put_en) begin
				res_read_q   <= 1'b0;
				res_scroll_q <= scroll;
				cur_col_q    <= next_col;
				cur_row_q    <= next_row;
				if (scroll) begin
					// old top row becomes the blank last row
					cur_prow_q <= base_q;
					fill_row_q <= base_q;
					fill_col_q <= '0;
					base_q     <= base_inc;
				end else if (adv_row) begin
					cur_prow_q <= prow_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.res_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			if (ctl.res_direct) begin
				cell_word      <= '0;
				cursor_row_now <= ROW_W'(next_row);
				cursor_col_now <= COL_W'(next_col);
				did_scroll     <= 1'b0;
			end else begin
				cell_word      <= (res_read_q && rd_ok_q) ? rdata_q : '0;
				cursor_row_now <= ROW_W'(cur_row_q);
				cursor_col_now <= COL_W'(cur_col_q);
				did_scroll     <= res_scroll_q;
			end
		end
	end

endmodule

/* rtl/text_console_cell_writer.sv */
`timescale 1ns / 1ps
// put item: result loaded into the output registers, one put per cycle while the output is taken and no scroll is due
// read item: result passes the registered cell store read port, then the output registers
// scroll: one blank cell written per cycle into the recycled row
// reset: async active low; then a clearing pass zeroes the store
//   with in_ready low; fill attribute resets to 0x07 and writes are taken throughout

module text_console_cell_writer #(
	parameter int COLS = tcw_pkg::COLS_DEF,
	parameter int ROWS = tcw_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::ATTR_W-1:0]  attribute,
	input  logic [tcw_pkg::ROW_W-1:0]   read_row,
	input  logic [tcw_pkg::COL_W-1:0]   read_col,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tcw_pkg::CELL_W-1:0]  cell_word,
	output logic [tcw_pkg::ROW_W-1:0]   cursor_row_now,
	output logic [tcw_pkg::COL_W-1:0]   cursor_col_now,
	output logic                        did_scroll
);
	import tcw_pkg::*;

	`include "text_console_cell_writer_macros.svh"

	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.sts      (sts),
		.in_ready (in_ready),
		.ctl      (ctl)
	);

	tcw_datapath #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_data       (cfg_data),
		.char_code      (char_code),
		.attribute      (attribute),
		.read_row       (read_row),
		.read_col       (read_col),
		.ctl            (ctl),
		.sts            (sts),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.cell_word      (cell_word),
		.cursor_row_now (cursor_row_now),
		.cursor_col_now (cursor_col_now),
		.did_scroll     (did_scroll)
	);

	`TCW_ASSERT(a_scroll_cursor, (out_valid && did_scroll) |-> (cursor_row_now == ROW_W'(ROWS - 1) && cursor_col_now == '0 && cell_word == '0))
	`TCW_ASSERT_NEVER(a_busy_ready, (ctl.clear_en || ctl.fill_en) && in_ready)
	`TCW_ASSERT(a_direct_put, (in_valid && in_ready && mode == MODE_PUT && !sts.scroll_req && !out_valid) |=> (out_valid && !did_scroll && cell_word == '0))

endmodule

/* tb/console_cell_checker.sv */
`timescale 1ns / 1ps

module console_cell_checker #(
	parameter int COLS = tcw_pkg::COLS_DEF,
	parameter int ROWS = tcw_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        mode,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::ATTR_W-1:0]  attribute,
	input  logic [tcw_pkg::ROW_W-1:0]   read_row,
	input  logic [tcw_pkg::COL_W-1:0]   read_col,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [tcw_pkg::CELL_W-1:0]  cell_word,
	input  logic [tcw_pkg::ROW_W-1:0]   cursor_row_now,
	input  logic [tcw_pkg::COL_W-1:0]   cursor_col_now,
	input  logic                        did_scroll,
	output int                          mismatches,
	output int                          results_due,
	output int                          results_seen,
	output int                          scrolls_seen
);

	typedef struct packed {
		logic [tcw_pkg::CELL_W-1:0] cell_val;
		logic [tcw_pkg::ROW_W-1:0]  row;
		logic [tcw_pkg::COL_W-1:0]  col;
		logic                       scrolled;
	} console_result_t;

	logic [tcw_pkg::CELL_W-1:0] shadow_cells [ROWS*COLS];
	logic [tcw_pkg::ROW_W-1:0]  shadow_row;
	logic [tcw_pkg::COL_W-1:0]  shadow_col;
	logic [tcw_pkg::ATTR_W-1:0] shadow_fill;
	console_result_t            cell_results_due [$];
	console_result_t            oldest;

	function automatic console_result_t advance_console(
		input logic                       md,
		input logic [tcw_pkg::CHAR_W-1:0] ch,
		input logic [tcw_pkg::ATTR_W-1:0] attr,
		input logic [tcw_pkg::ROW_W-1:0]  rrow,
		input logic [tcw_pkg::COL_W-1:0]  rcol
	);
		console_result_t res;
		int next_row;
		int next_col;
		int idx;
		res = '0;
		if (md == tcw_pkg::MODE_READ) begin
			if (rrow < ROWS && rcol < COLS)
				res.cell_val = shadow_cells[rrow * COLS + rcol];
		end else begin
			next_row = shadow_row;
			next_col = shadow_col;
			if (ch == tcw_pkg::NEWLINE_CODE) begin
				next_col = 0;
				next_row++;
			end else begin
				shadow_cells[next_row * COLS + next_col] = {attr, ch};
				next_col++;
				if (next_col >= COLS) begin
					next_col = 0;
					next_row++;
				end
			end
			if (next_row >= ROWS) begin
				for (idx = 0; idx < (ROWS - 1) * COLS; idx++)
					shadow_cells[idx] = shadow_cells[idx + COLS];
				for (idx = (ROWS - 1) * COLS; idx < ROWS * COLS; idx++)
					shadow_cells[idx] = {shadow_fill, tcw_pkg::SPACE_CODE};
				next_row = ROWS - 1;
				res.scrolled = 1'b1;
			end
			shadow_row = next_row[tcw_pkg::ROW_W-1:0];
			shadow_col = next_col[tcw_pkg::COL_W-1:0];
		end
		res.row = shadow_row;
		res.col = shadow_col;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int idx = 0; idx < ROWS * COLS; idx++)
				shadow_cells[idx] = '0;
			shadow_row = '0;
			shadow_col = '0;
			shadow_fill = tcw_pkg::FILL_RESET;
			cell_results_due.delete();
			mismatches = 0;
			results_seen = 0;
			scrolls_seen = 0;
			results_due <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (did_scroll === 1'b1)
					scrolls_seen++;
				if (cell_results_due.size() == 0) begin
					$display("%0t ns: unexpected result beat, cell 0x%0h row %0d col %0d scroll %0b",
						$time, cell_word, cursor_row_now, cursor_col_now, did_scroll);
					mismatches++;
				end else begin
					oldest = cell_results_due.pop_front();
					check_field("cell_word", oldest.cell_val, cell_word);
					check_field("cursor_row_now", 16'(oldest.row), 16'(cursor_row_now));
					check_field("cursor_col_now", 16'(oldest.col), 16'(cursor_col_now));
					check_field("did_scroll", 16'(oldest.scrolled), 16'(did_scroll));
				end
			end
			if (cfg_valid && cfg_ready)
				shadow_fill = cfg_data;
			if (in_valid && in_ready)
				cell_results_due.push_back(advance_console(mode, char_code, attribute,
					read_row, read_col));
			results_due <= cell_results_due.size();
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int COLS            = tcw_pkg::COLS_DEF;
	localparam int ROWS            = tcw_pkg::ROWS_DEF;
	localparam int ITEMS_PER_PHASE = 108;
	localparam int SETTLE_CYCLES   = COLS + 8;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [tcw_pkg::ATTR_W-1:0]  cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic                        mode = tcw_pkg::MODE_PUT;
	logic [tcw_pkg::CHAR_W-1:0]  char_code = '0;
	logic [tcw_pkg::ATTR_W-1:0]  attribute = '0;
	logic [tcw_pkg::ROW_W-1:0]   read_row = '0;
	logic [tcw_pkg::COL_W-1:0]   read_col = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [tcw_pkg::CELL_W-1:0]  cell_word;
	logic [tcw_pkg::ROW_W-1:0]   cursor_row_now;
	logic [tcw_pkg::COL_W-1:0]   cursor_col_now;
	logic                        did_scroll;

	int mismatches;
	int results_due;
	int results_seen;
	int scrolls_seen;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int reads_sent = 0;
	int newlines_sent = 0;
	int random_fill;

	text_console_cell_writer i_dut (.*);

	console_cell_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("text_console_cell_writer verification failed");
		$finish;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	task automatic send_beat(input logic md, input int ch, input int attr,
		input int rrow, input int rcol);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= md;
		char_code <= ch[tcw_pkg::CHAR_W-1:0];
		attribute <= attr[tcw_pkg::ATTR_W-1:0];
		read_row  <= rrow[tcw_pkg::ROW_W-1:0];
		read_col  <= rcol[tcw_pkg::COL_W-1:0];
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (md == tcw_pkg::MODE_READ)
			reads_sent++;
		else if (ch == tcw_pkg::NEWLINE_CODE)
			newlines_sent++;
	endtask

	task automatic send_put(input int ch, input int attr);
		send_beat(tcw_pkg::MODE_PUT, ch, attr, $urandom_range(0, 31), $urandom_range(0, 127));
	endtask

	task automatic send_read(input int rrow, input int rcol);
		send_beat(tcw_pkg::MODE_READ, $urandom_range(0, 255), $urandom_range(0, 255), rrow, rcol);
	endtask

	task automatic send_random_read();
		if ($urandom_range(0, 4) == 0)
			send_read($urandom_range(0, 31), $urandom_range(0, 127));
		else
			send_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	task automatic write_fill(input int value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value[tcw_pkg::ATTR_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// text bursts, newline runs and read bursts; long bursts can run past the end of a row
	task automatic run_random(input int count);
		int stop_at;
		int seg_len;
		int pick;
		int ch;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				seg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 95) : $urandom_range(1, 20);
			else if (pick < 7)
				seg_len = $urandom_range(1, 8);
			else
				seg_len = $urandom_range(1, 6);
			if (seg_len > stop_at - items_sent)
				seg_len = stop_at - items_sent;
			repeat (seg_len) begin
				if (pick < 4) begin
					if ($urandom_range(0, 9) == 0) begin
						send_random_read();
					end else begin
						do ch = $urandom_range(0, 255); while (ch == tcw_pkg::NEWLINE_CODE);
						send_put(ch, $urandom_range(0, 255));
					end
				end else if (pick < 7) begin
					send_put(tcw_pkg::NEWLINE_CODE, $urandom_range(0, 255));
				end else begin
					send_random_read();
				end
			end
			if ($urandom_range(0, 19) == 0)
				drain_results();
		end
	endtask

	initial begin
		random_fill = $urandom_range(1, 254);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty store, field extremes, out of range reads
		send_read(0, 0);
		send_put(8'h00, 8'h00);
		send_put(8'hFF, 8'hFF);
		send_put(8'h41, 8'h1E);
		send_put(8'h55, 8'hAA);
		send_put(8'hAA, 8'h55);
		send_read(0, 1);
		send_read(0, 4);
		send_read(ROWS - 1, COLS - 1);
		send_read(ROWS, 0);
		send_read(0, COLS);
		send_read(31, 127);
		send_read(ROWS - 1, 127);
		send_put(tcw_pkg::NEWLINE_CODE, 8'hFF);
		send_put(8'h0B, 8'h00);
		send_put(8'h09, 8'hFF);
		send_put(tcw_pkg::NEWLINE_CODE, 8'h00);
		send_read(1, 0);
		send_read(1, 1);
		send_read(2, 0);

		run_random(ITEMS_PER_PHASE);

		write_fill(8'h00);
		send_idle_pct = 75;
		recv_stall_pct = 0;
		run_random(ITEMS_PER_PHASE);

		write_fill(8'hFF);
		send_idle_pct = 0;
		recv_stall_pct = 75;
		run_random(ITEMS_PER_PHASE);

		write_fill(random_fill);
		send_idle_pct = 37;
		recv_stall_pct = 37;
		run_random(ITEMS_PER_PHASE);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d items (%0d reads, %0d newlines), %0d results checked, %0d scrolls",
			items_sent, reads_sent, newlines_sent, results_seen, scrolls_seen);
		$display("fill attribute 0x07, 0x00, 0xFF, 0x%02h under idle mixes 0/0, 75/0, 0/75, 37/37",
			random_fill);
		if (mismatches == 0 && results_due == 0)
			$display("text_console_cell_writer verification clean");
		else
			$display("text_console_cell_writer verification failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_cell_writer.sv
tb/console_cell_checker.sv
tb/testbench.sv
